/* src/split_crc32c_fingerprint_macros.svh */
// ----------------------------------------------------------------------------
// split_crc32c_fingerprint assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef SPLIT_CRC32C_FINGERPRINT_MACROS_SVH
`define SPLIT_CRC32C_FINGERPRINT_MACROS_SVH

`ifndef ASSERT_OFF
`define SCF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scf assertion failed");
`define SCF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("scf forbidden condition seen");
`else
`define SCF_ASSERT(lbl, clk, rst_n, prop)
`define SCF_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* src/scf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_pkg
// shared constants, types and the bytewise crc-32c update
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam logic [31:0] CRC_POLY_REFL = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT    = 32'hFFFF_FFFF;
    localparam logic [31:0] PRINT_SALT    = 32'h9E37_79B9;

    localparam int LEN_W  = 32;
    localparam int BYTE_W = 8;
    localparam int CRC_W  = 32;

    typedef struct packed {
        logic              en;
        logic              clear;
        logic              feed;
        logic [BYTE_W-1:0] data;
    } t_crc_ctl;

    function automatic logic [CRC_W-1:0] crc_feed(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] byte_in
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, byte_in};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* src/scf_crc_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scf_crc_unit
// one crc-32c engine: running register with clear and bytewise feed
// ----------------------------------------------------------------------------
module scf_crc_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  scf_pkg::t_crc_ctl          i_ctl,
    output logic [scf_pkg::CRC_W-1:0]  o_crc_next
);

    logic [scf_pkg::CRC_W-1:0] r_crc;
    logic [scf_pkg::CRC_W-1:0] n_crc;
    logic [scf_pkg::CRC_W-1:0] crc_base;

    always_comb begin
        crc_base = i_ctl.clear ? scf_pkg::CRC_INIT : r_crc;
        n_crc    = i_ctl.feed ? scf_pkg::crc_feed(crc_base, i_ctl.data) : crc_base;
    end

    assign o_crc_next = n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= scf_pkg::CRC_INIT;
        end else if (i_ctl.en) begin
            r_crc <= n_crc;
        end
    end

endmodule

/* src/split_crc32c_fingerprint.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_crc32c_fingerprint
// two crc-32c engines over the halves of a message, 128-bit fingerprint out
// ----------------------------------------------------------------------------
// channel   dir  tdata                                  tuser
// s_axis    in   [7:0] byte_value, [39:8] total_length  [0] message_start
// m_axis    out  [63:0] print_high, [127:64] print_low  -
//
// one item per cycle while the result side is not stalled; the result is registered
// after the last byte is accepted (input register, then crc update into the result register)
// the bytewise crc xor network and the 32-bit position compare set the path
// synchronous active-low reset; both crc engines return to all ones, idle
// a stalled result holds in the output register; one more item may wait in
// the input register meanwhile
// ----------------------------------------------------------------------------
`include "split_crc32c_fingerprint_macros.svh"

module split_crc32c_fingerprint (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // byte_value, total_length
    input  logic         s_axis_tuser,   // message_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // print_high, print_low
);

    localparam int LEN_W  = scf_pkg::LEN_W;
    localparam int BYTE_W = scf_pkg::BYTE_W;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic [LEN_W-1:0]  r_in_len;

    // message state
    logic [LEN_W-1:0]  r_pos;
    logic [LEN_W-1:0]  r_len;

    // output register
    logic              r_out_valid;
    logic [127:0]      r_out_data;

    logic              out_free;
    logic              fire;
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  pos_eff;
    logic [LEN_W-1:0]  pos_next;
    logic [LEN_W-1:0]  half;
    logic              active;
    logic              empty;
    logic              in_first;
    logic              feed_a;
    logic              feed_b;
    logic              done;
    logic              result;
    logic [127:0]      n_out_data;

    scf_pkg::t_crc_ctl    ctl_a;
    scf_pkg::t_crc_ctl    ctl_b;
    logic [scf_pkg::CRC_W-1:0] crc_a;
    logic [scf_pkg::CRC_W-1:0] crc_b;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || fire;

    always_comb begin
        len_eff  = r_in_start ? r_in_len : r_len;
        pos_eff  = r_in_start ? '0 : r_pos;
        active   = r_in_start || (r_pos < r_len);
        empty    = r_in_start && (r_in_len == '0);
        half     = len_eff >> 1;
        in_first = pos_eff < half;
        feed_a   = active && !empty && ((half == '0) || in_first);
        feed_b   = active && !empty && ((half == '0) || !in_first);
        pos_next = pos_eff + LEN_W'(1);
        done     = active && !empty && (pos_next == len_eff);
        result   = empty || done;
    end

    always_comb begin
        ctl_a.en    = fire && active;
        ctl_a.clear = r_in_start;
        ctl_a.feed  = feed_a;
        ctl_a.data  = r_in_byte;
        ctl_b.en    = fire && active;
        ctl_b.clear = r_in_start;
        ctl_b.feed  = feed_b;
        ctl_b.data  = r_in_byte;
    end

    scf_crc_unit u_crc_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl_a),
        .o_crc_next (crc_a)
    );

    scf_crc_unit u_crc_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl_b),
        .o_crc_next (crc_b)
    );

    always_comb begin
        if (empty) begin
            n_out_data = '0;
        end else begin
            n_out_data = {crc_b ^ scf_pkg::CRC_XOROUT, scf_pkg::PRINT_SALT ^ half,
                          crc_a ^ scf_pkg::CRC_XOROUT, len_eff};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_byte  <= '0;
            r_in_len   <= '0;
            r_in_start <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata[BYTE_W-1:0];
            r_in_len   <= s_axis_tdata[BYTE_W +: LEN_W];
            r_in_start <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
        end else if (fire) begin
            if (r_in_start) begin
                r_len <= r_in_len;
            end
            if (empty) begin
                r_pos <= '0;
            end else if (active) begin
                r_pos <= pos_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && result) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `SCF_ASSERT(a_pos_in_range, i_clk, i_rst_n, r_pos <= r_len)
    `SCF_ASSERT(a_result_ends_msg, i_clk, i_rst_n, (fire && result) |=> (r_pos == r_len))
    `SCF_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, fire && r_out_valid && !m_axis_tready)
    `SCF_ASSERT_NEVER(a_both_only_short, i_clk, i_rst_n, feed_a && feed_b && (half != '0))

endmodule

/* tb/sv/fingerprint_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fingerprint_checker
// follows both stream channels of the split crc-32c fingerprint block, keeps
// its own copy of the two crc engines and the message position, works out
// the fingerprint due at the end of every message and compares each result
// against the oldest one still owed
// ----------------------------------------------------------------------------
module fingerprint_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_tvalid,
    input  logic         i_in_tready,
    input  logic [39:0]  i_in_tdata,    // byte_value, total_length
    input  logic         i_in_tuser,    // message_start
    input  logic         i_out_tvalid,
    input  logic         i_out_tready,
    input  logic [127:0] i_out_tdata,   // print_high, print_low
    output int           o_fail_count,
    output int           o_pending
);

    localparam logic [31:0] CASTAGNOLI_REFL = 32'h82F6_3B78;
    localparam logic [31:0] CRC_SEED        = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_FINAL_XOR   = 32'hFFFF_FFFF;
    localparam logic [31:0] LOW_WORD_SALT   = 32'h9E37_79B9;

    logic [31:0]  crc_a       = CRC_SEED;
    logic [31:0]  crc_b       = CRC_SEED;
    logic [31:0]  msg_pos     = '0;
    logic [31:0]  msg_len     = '0;
    logic [127:0] prints_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                                input logic [7:0] data);
        logic [31:0] r;
        r = crc ^ {24'd0, data};
        repeat (8) r = r[0] ? ((r >> 1) ^ CASTAGNOLI_REFL) : (r >> 1);
        return r;
    endfunction

    // one accepted byte; returns 1 when it finishes a fingerprint
    function automatic bit absorb_byte(input logic [7:0] value, input logic start,
                                       input logic [31:0] length,
                                       output logic [127:0] print);
        logic [31:0] half;
        print = '0;
        if (start) begin
            msg_len = length;
            msg_pos = '0;
            crc_a   = CRC_SEED;
            crc_b   = CRC_SEED;
            if (length == 0) begin
                return 1'b1;
            end
        end else if (msg_pos >= msg_len) begin
            return 1'b0;
        end
        half = msg_len >> 1;
        if (half == 0) begin
            crc_a = crc32c_byte(crc_a, value);
            crc_b = crc32c_byte(crc_b, value);
        end else if (msg_pos < half) begin
            crc_a = crc32c_byte(crc_a, value);
        end else begin
            crc_b = crc32c_byte(crc_b, value);
        end
        msg_pos = msg_pos + 32'd1;
        if (msg_pos != msg_len) begin
            return 1'b0;
        end
        print = {crc_b ^ CRC_FINAL_XOR, LOW_WORD_SALT ^ half, crc_a ^ CRC_FINAL_XOR, msg_len};
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        logic [127:0] print;
        logic [127:0] owed;
        if (!i_rst_n) begin
            crc_a   = CRC_SEED;
            crc_b   = CRC_SEED;
            msg_pos = '0;
            msg_len = '0;
        end else begin
            // results first, so a result never meets an expectation of the same edge
            if (i_out_tvalid && i_out_tready) begin
                if (prints_due.size() == 0) begin
                    report_mismatch("unexpected result, print_high", i_out_tdata[63:0], '0);
                end else begin
                    owed = prints_due.pop_front();
                    if (i_out_tdata[63:0] !== owed[63:0]) begin
                        report_mismatch("print_high", i_out_tdata[63:0], owed[63:0]);
                    end
                    if (i_out_tdata[127:64] !== owed[127:64]) begin
                        report_mismatch("print_low", i_out_tdata[127:64], owed[127:64]);
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                if (absorb_byte(i_in_tdata[7:0], i_in_tuser, i_in_tdata[39:8], print)) begin
                    prints_due.push_back(print);
                end
            end
        end
        o_pending <= prints_due.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// byte stream stimulus for split_crc32c_fingerprint: a directed run through
// empty, one-byte, restarted and stray-byte cases, then random messages with
// broken and empty ones mixed in, random gaps on both channels
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_TARGET    = 1800;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata  = '0;   // byte_value, total_length
    logic         s_axis_tuser  = 1'b0; // message_start
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;         // print_high, print_low

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit no_gaps      = 1'b0;
    bit result_taken = 1'b0;

    always #5 i_clk = ~i_clk;

    split_crc32c_fingerprint u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fingerprint_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side stall, drawn afresh after every taken result
    always @(posedge i_clk) begin
        result_taken <= m_axis_tvalid && m_axis_tready;
    end

    always @(negedge i_clk) begin
        if (result_taken) begin
            stall_left = no_gaps ? 0 : $urandom_range(0, 3);
        end
        if (!i_rst_n || stall_left > 0) begin
            m_axis_tready <= 1'b0;
            if (stall_left > 0) begin
                stall_left--;
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] value, input logic start,
                             input logic [31:0] length);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {length, value};
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // count bytes of a message announced as length bytes long
    task automatic send_message(input logic [31:0] length, input int count);
        send_byte(8'($urandom_range(0, 255)), 1'b1, length);
        for (int k = 1; k < count; k++) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom());
        end
    endtask

    initial begin : stimulus
        int          sent;
        int          pick;
        int          count;
        logic [31:0] length;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // stray byte while idle, empty message, one-, two- and three-byte messages
        send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b1, 32'h0000_0000);
        send_byte(8'h00, 1'b1, 32'd1);
        send_byte(8'hFF, 1'b1, 32'd1);
        send_byte(8'hFF, 1'b1, 32'd2);
        send_byte(8'h00, 1'b0, 32'h0000_0000);
        send_byte(8'h80, 1'b1, 32'd3);
        send_byte(8'h01, 1'b0, 32'hFFFF_FFFF);
        send_byte(8'h7F, 1'b0, 32'd3);
        // longest length, then restarts mid-message, empty one among them
        send_byte(8'hA5, 1'b1, 32'hFFFF_FFFF);
        send_byte(8'h5A, 1'b0, 32'h0000_0000);
        send_byte(8'h3C, 1'b1, 32'hAAAA_AAAA);
        send_byte(8'hC3, 1'b1, 32'h5555_5555);
        send_byte(8'h11, 1'b1, 32'h0000_0000);
        send_byte(8'h22, 1'b0, 32'd5);
        send_byte(8'h01, 1'b1, 32'd5);
        send_byte(8'h02, 1'b0, 32'd5);
        send_byte(8'h10, 1'b1, 32'd4);
        send_byte(8'h20, 1'b0, 32'd4);
        send_byte(8'h40, 1'b0, 32'd4);
        send_byte(8'hFE, 1'b0, 32'd4);
        // stray byte after completion
        send_byte(8'h77, 1'b0, 32'd9);

        sent = 0;
        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 39) == 0) begin
                no_gaps = !no_gaps;
            end
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                count = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64)
                                                     : $urandom_range(1, 16);
                send_message(count, count);
                sent += count;
            end else if (pick < 88) begin
                // message cut short by whatever comes next
                length = $urandom_range(0, 1) ? $urandom() : $urandom_range(6, 16);
                count  = $urandom_range(1, 5);
                send_message(length, count);
                sent += count;
            end else if (pick < 93) begin
                send_byte(8'($urandom_range(0, 255)), 1'b1, 32'h0000_0000);
                sent++;
            end else begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom());
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* split_crc32c_fingerprint.f */
+incdir+src
src/scf_pkg.sv
src/scf_crc_unit.sv
src/split_crc32c_fingerprint.sv
tb/sv/fingerprint_checker.sv
tb/sv/testbench.sv
